### hw/rtl/iaal_pkg.sv
// Shared types, widths and filter coefficients for the IMU align and low-pass block.
package iaal_pkg;

	// Sample and intermediate widths
	localparam int SAMPLE_W   = 16;
	localparam int GYRO_W     = SAMPLE_W + 1;   // raw minus bias
	localparam int RATE_SUM_W = GYRO_W + 3;     // three signed terms, negation included
	localparam int ACC_SUM_W  = SAMPLE_W + 3;
	localparam int ROW_W      = 6;              // three 2-bit codes per matrix row
	localparam int MAT_W      = 3 * ROW_W;

	// Filter fixed point: Q2.29 coefficients, 24 fractional state bits
	localparam int STATE_W    = 48;
	localparam int STATE_FRAC = 24;
	localparam int COEF_W     = 31;
	localparam int COEF_B_W   = 22;
	localparam int COEF_FRAC  = 29;
	localparam int BX_W       = COEF_B_W + ACC_SUM_W;
	localparam int SUM_W      = 82;

	localparam logic signed [COEF_W-1:0]   COEF_A1 = 31'sd1035867750;
	localparam logic signed [COEF_W-1:0]   COEF_A2 = -31'sd500247456;
	localparam logic signed [COEF_B_W-1:0] COEF_B  = 22'sd1250619;

	// Configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 18;
	localparam logic [CFG_IDX_W-1:0] CFG_GYRO_MAT  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_MAT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BIAS_X    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_BIAS_Y    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_BIAS_Z    = 3'd4;
	localparam logic [MAT_W-1:0]     MAT_IDENTITY  = 18'h10101;

	// Input request payload
	typedef struct packed {
		logic signed [SAMPLE_W-1:0] raw_gyro_x;
		logic signed [SAMPLE_W-1:0] raw_gyro_y;
		logic signed [SAMPLE_W-1:0] raw_gyro_z;
		logic signed [SAMPLE_W-1:0] raw_accel_x;
		logic signed [SAMPLE_W-1:0] raw_accel_y;
		logic signed [SAMPLE_W-1:0] raw_accel_z;
	} sample_t;

	// Result request payload
	typedef struct packed {
		logic signed [SAMPLE_W-1:0] rate_x;
		logic signed [SAMPLE_W-1:0] rate_y;
		logic signed [SAMPLE_W-1:0] rate_z;
		logic signed [SAMPLE_W-1:0] smooth_accel_x;
		logic signed [SAMPLE_W-1:0] smooth_accel_y;
		logic signed [SAMPLE_W-1:0] smooth_accel_z;
	} result_t;

	// Bias-corrected sample held in the first stage
	typedef struct packed {
		logic signed [GYRO_W-1:0]   gyro_x;
		logic signed [GYRO_W-1:0]   gyro_y;
		logic signed [GYRO_W-1:0]   gyro_z;
		logic signed [SAMPLE_W-1:0] accel_x;
		logic signed [SAMPLE_W-1:0] accel_y;
		logic signed [SAMPLE_W-1:0] accel_z;
	} corr_t;

	// Pipeline control from the top level to the lanes
	typedef struct packed {
		logic ld_s2;   // stage 2 registers load
		logic upd;     // a request moves into stage 3: advance filter state
	} pipe_ctl_t;

endpackage

### hw/rtl/iaal_rot_lane.sv
// One axis lane: matrix row applied to gyro and accel, rate saturation, b*x product.
module iaal_rot_lane
	import iaal_pkg::*;
(
	input  logic                        clk,
	input  pipe_ctl_t                   ctl,
	input  logic [ROW_W-1:0]            gyro_row,
	input  logic [ROW_W-1:0]            accel_row,
	input  corr_t                       samp,
	output logic signed [SAMPLE_W-1:0]  rate_s2,
	output logic signed [BX_W-1:0]      bx_s2
);

	// Mounting matrix codes; the fourth code counts as zero
	localparam logic [1:0] MAT_ZERO  = 2'd0;
	localparam logic [1:0] MAT_PLUS  = 2'd1;
	localparam logic [1:0] MAT_MINUS = 2'd2;

	function automatic logic signed [RATE_SUM_W-1:0] gterm(
		input logic [1:0] code, input logic signed [GYRO_W-1:0] v);
		logic signed [RATE_SUM_W-1:0] r;
		case (code)
			MAT_PLUS:  r = RATE_SUM_W'(v);
			MAT_MINUS: r = -RATE_SUM_W'(v);
			MAT_ZERO:  r = '0;
			default:   r = '0;
		endcase
		return r;
	endfunction

	function automatic logic signed [ACC_SUM_W-1:0] aterm(
		input logic [1:0] code, input logic signed [SAMPLE_W-1:0] v);
		logic signed [ACC_SUM_W-1:0] r;
		case (code)
			MAT_PLUS:  r = ACC_SUM_W'(v);
			MAT_MINUS: r = -ACC_SUM_W'(v);
			MAT_ZERO:  r = '0;
			default:   r = '0;
		endcase
		return r;
	endfunction

	logic signed [RATE_SUM_W-1:0] rate_sum;
	logic signed [ACC_SUM_W-1:0]  acc_sum;
	logic signed [SAMPLE_W-1:0]   rate_sat;
	logic signed [BX_W-1:0]       bx_c;

	// Row dot products
	always_comb begin
		rate_sum = gterm(gyro_row[1:0], samp.gyro_x) + gterm(gyro_row[3:2], samp.gyro_y)
			+ gterm(gyro_row[5:4], samp.gyro_z);
		acc_sum = aterm(accel_row[1:0], samp.accel_x) + aterm(accel_row[3:2], samp.accel_y)
			+ aterm(accel_row[5:4], samp.accel_z);
	end

	// Saturate rate to the sample range
	always_comb begin
		if (rate_sum[RATE_SUM_W-1:SAMPLE_W-1] == {(RATE_SUM_W-SAMPLE_W+1){1'b0}} ||
				rate_sum[RATE_SUM_W-1:SAMPLE_W-1] == {(RATE_SUM_W-SAMPLE_W+1){1'b1}}) begin
			rate_sat = rate_sum[SAMPLE_W-1:0];
		end else begin
			rate_sat = {rate_sum[RATE_SUM_W-1], {(SAMPLE_W-1){~rate_sum[RATE_SUM_W-1]}}};
		end
	end

	// Feed-forward term of the filter, taken out of the recursion
	assign bx_c = BX_W'(COEF_B) * BX_W'(acc_sum);

	always_ff @(posedge clk) begin
		if (ctl.ld_s2) begin
			rate_s2 <= rate_sat;
			bx_s2   <= bx_c;
		end
	end

endmodule

### hw/rtl/iaal_iir_lane.sv
// One axis of the second-order low-pass: state update and output rounding.
module iaal_iir_lane
	import iaal_pkg::*;
(
	input  logic                        clk,
	input  logic                        arst_n,
	input  pipe_ctl_t                   ctl,
	input  logic signed [BX_W-1:0]      bx_s2,
	output logic signed [SAMPLE_W-1:0]  smooth
);

	localparam int PH_W  = COEF_W + STATE_W - STATE_FRAC;   // coef x high half
	localparam int PL_W  = COEF_W + STATE_FRAC + 1;         // coef x low half
	localparam int A2T_W = COEF_W + STATE_W;
	localparam int Y_W   = SUM_W - COEF_FRAC;
	localparam int RND_W = STATE_W + 1;
	localparam int YI_W  = RND_W - STATE_FRAC;
	localparam logic signed [SUM_W-1:0] RND_STATE =
		{{(SUM_W-COEF_FRAC){1'b0}}, 1'b1, {(COEF_FRAC-1){1'b0}}};
	localparam logic signed [RND_W-1:0] RND_OUT =
		{{(RND_W-STATE_FRAC){1'b0}}, 1'b1, {(STATE_FRAC-1){1'b0}}};

	// last output and a2 times the before-last output
	logic signed [STATE_W-1:0] y1_q;
	logic signed [A2T_W-1:0]   a2t_q;

	logic signed [STATE_FRAC:0]         y1_lo;
	logic signed [STATE_W-STATE_FRAC-1:0] y1_hi;
	logic signed [PH_W-1:0]   a1_hi, a2_hi;
	logic signed [PL_W-1:0]   a1_lo, a2_lo;
	logic signed [A2T_W-1:0]  a2t_next;
	logic signed [SUM_W-1:0]  n_sum;
	logic signed [Y_W-1:0]    y_full;
	logic signed [STATE_W-1:0] y_new;
	logic signed [RND_W-1:0]  y_rnd;
	logic signed [YI_W-1:0]   y_int;

	// Split the last output so each product stays near 31x25 bits
	assign y1_hi = y1_q[STATE_W-1:STATE_FRAC];
	assign y1_lo = {1'b0, y1_q[STATE_FRAC-1:0]};
	assign a1_hi = PH_W'(COEF_A1) * PH_W'(y1_hi);
	assign a1_lo = PL_W'(COEF_A1) * PL_W'(y1_lo);
	assign a2_hi = PH_W'(COEF_A2) * PH_W'(y1_hi);
	assign a2_lo = PL_W'(COEF_A2) * PL_W'(y1_lo);

	// a2 term for the next update: old last becomes before-last
	assign a2t_next = (A2T_W'(a2_hi) <<< STATE_FRAC) + A2T_W'(a2_lo);

	// New state: floor of the rounded Q29 sum, saturated to 48 bits
	always_comb begin
		n_sum = (SUM_W'(a1_hi) <<< STATE_FRAC) + SUM_W'(a1_lo) + SUM_W'(a2t_q)
			+ (SUM_W'(bx_s2) <<< STATE_FRAC) + RND_STATE;
		y_full = n_sum[SUM_W-1:COEF_FRAC];
		if (y_full[Y_W-1:STATE_W-1] == {(Y_W-STATE_W+1){1'b0}} ||
				y_full[Y_W-1:STATE_W-1] == {(Y_W-STATE_W+1){1'b1}}) begin
			y_new = y_full[STATE_W-1:0];
		end else begin
			y_new = {y_full[Y_W-1], {(STATE_W-1){~y_full[Y_W-1]}}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			y1_q  <= '0;
			a2t_q <= '0;
		end else if (ctl.upd) begin
			y1_q  <= y_new;
			a2t_q <= a2t_next;
		end
	end

	// Round half up to an integer and saturate; y1_q belongs to the request in stage 3
	always_comb begin
		y_rnd = RND_W'(y1_q) + RND_OUT;
		y_int = y_rnd[RND_W-1:STATE_FRAC];
		if (y_int[YI_W-1:SAMPLE_W-1] == {(YI_W-SAMPLE_W+1){1'b0}} ||
				y_int[YI_W-1:SAMPLE_W-1] == {(YI_W-SAMPLE_W+1){1'b1}}) begin
			smooth = y_int[SAMPLE_W-1:0];
		end else begin
			smooth = {y_int[YI_W-1], {(SAMPLE_W-1){~y_int[YI_W-1]}}};
		end
	end

endmodule

### hw/rtl/imu_axis_align_and_lowpass.sv
// Top level: config registers, bias stage, three axis lanes and result register.
// Path: an accepted request moves through the bias stage, stages 2 and 3, result register.
// Throughput: one request per cycle while result_stall is low; the filter recursion never holds the flow.
// Stall back-pressure ripples through four stages; bubbles are squeezed out.
// Reset clears stage valids and filter history and loads identity matrices, zero bias.
module imu_axis_align_and_lowpass
	import iaal_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   sample_valid,
	output logic                   sample_stall,
	input  sample_t                sample,
	output logic                   result_valid,
	input  logic                   result_stall,
	output result_t                result,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	logic [MAT_W-1:0]           gmat_q, amat_q;
	logic signed [SAMPLE_W-1:0] bias_x_q, bias_y_q, bias_z_q;

	logic    vld_s1, vld_s2, vld_s3, out_vld_q;
	logic    rdy_s1, rdy_s2, rdy_s3, rdy_s4;
	corr_t   samp_s1;
	result_t result_q;
	pipe_ctl_t ctl;

	logic signed [SAMPLE_W-1:0] rate_s2 [3];
	logic signed [SAMPLE_W-1:0] rate_s3 [3];
	logic signed [BX_W-1:0]     bx_s2 [3];
	logic signed [SAMPLE_W-1:0] smooth [3];

	// Configuration writes, always accepted
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gmat_q   <= MAT_IDENTITY;
			amat_q   <= MAT_IDENTITY;
			bias_x_q <= '0;
			bias_y_q <= '0;
			bias_z_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_GYRO_MAT:  gmat_q   <= cfg_data;
				CFG_ACCEL_MAT: amat_q   <= cfg_data;
				CFG_BIAS_X:    bias_x_q <= cfg_data[SAMPLE_W-1:0];
				CFG_BIAS_Y:    bias_y_q <= cfg_data[SAMPLE_W-1:0];
				CFG_BIAS_Z:    bias_z_q <= cfg_data[SAMPLE_W-1:0];
				default: ;
			endcase
		end
	end

	// Handshake: a stage loads when it is empty or its content moves on
	assign rdy_s4       = !out_vld_q || !result_stall;
	assign rdy_s3       = !vld_s3 || rdy_s4;
	assign rdy_s2       = !vld_s2 || rdy_s3;
	assign rdy_s1       = !vld_s1 || rdy_s2;
	assign sample_stall = !rdy_s1;
	assign ctl.ld_s2    = rdy_s2;
	assign ctl.upd      = rdy_s3 && vld_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (rdy_s1) vld_s1 <= sample_valid;
			if (rdy_s2) vld_s2 <= vld_s1;
			if (rdy_s3) vld_s3 <= vld_s2;
			if (rdy_s4) out_vld_q <= vld_s3;
		end
	end

	// Stage 1: bias removal
	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			samp_s1.gyro_x  <= GYRO_W'(sample.raw_gyro_x) - GYRO_W'(bias_x_q);
			samp_s1.gyro_y  <= GYRO_W'(sample.raw_gyro_y) - GYRO_W'(bias_y_q);
			samp_s1.gyro_z  <= GYRO_W'(sample.raw_gyro_z) - GYRO_W'(bias_z_q);
			samp_s1.accel_x <= sample.raw_accel_x;
			samp_s1.accel_y <= sample.raw_accel_y;
			samp_s1.accel_z <= sample.raw_accel_z;
		end
	end

	// Stages 2 and 3: one lane per body axis
	for (genvar r = 0; r < 3; r++) begin : g_axis
		iaal_rot_lane u_rot (
			.clk       (clk),
			.ctl       (ctl),
			.gyro_row  (gmat_q[ROW_W*r +: ROW_W]),
			.accel_row (amat_q[ROW_W*r +: ROW_W]),
			.samp      (samp_s1),
			.rate_s2   (rate_s2[r]),
			.bx_s2     (bx_s2[r])
		);

		iaal_iir_lane u_iir (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.bx_s2  (bx_s2[r]),
			.smooth (smooth[r])
		);

		always_ff @(posedge clk) begin
			if (rdy_s3) rate_s3[r] <= rate_s2[r];
		end
	end

	// Merge the lanes into the result register
	always_ff @(posedge clk) begin
		if (rdy_s4) begin
			result_q.rate_x         <= rate_s3[0];
			result_q.rate_y         <= rate_s3[1];
			result_q.rate_z         <= rate_s3[2];
			result_q.smooth_accel_x <= smooth[0];
			result_q.smooth_accel_y <= smooth[1];
			result_q.smooth_accel_z <= smooth[2];
		end
	end

	assign result_valid = out_vld_q;
	assign result       = result_q;

	// Stall only when every stage holds a request
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		sample_stall |-> (vld_s1 && vld_s2 && vld_s3 && out_vld_q))
		else $error("input stalled with a free stage");

	// A request waiting in stage 2 is not lost
	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s2 && !rdy_s3) |=> vld_s2)
		else $error("stage 2 request dropped");

	// Each filter update hands its request to stage 3
	a_upd_s3: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.upd |=> vld_s3)
		else $error("filter advanced without a stage 3 request");

endmodule
